// File: rtl/core/dpl_pkg.sv
// Shared types and constants for the delayed dual-pin load driver.
// No dependencies; imported by every module of the block.
package dpl_pkg;

   localparam int DPL_MAX_LOADS = 8;

   typedef enum logic [1:0] {
      ACT_CLEAR    = 2'd0,
      ACT_REGISTER = 2'd1,
      ACT_COMMAND  = 2'd2,
      ACT_TICK     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   // static part of a table entry, written once per registration
   typedef struct packed {
      logic [7:0] pin_one;
      logic [7:0] pin_two;
      logic [7:0] on_delay;
      logic [7:0] off_delay;
   } load_cfg_type;

   // dynamic part of a table entry, updated by the walk
   typedef struct packed {
      logic [7:0] count;
      logic       level;
   } load_dyn_type;

   // operation in flight, handed to the evaluation unit
   typedef struct packed {
      logic       is_tick;
      logic [7:0] pin_one;
      logic [7:0] pin_two;
      logic       level;
   } op_type;

   typedef struct packed {
      logic         due;
      load_dyn_type next;
   } eval_type;

   typedef struct packed {
      logic cfg_we;
      logic cnt_we;
      logic lvl_we;
   } tbl_wr_type;

   typedef struct packed {
      logic [2:0] slot;
      logic [7:0] pin_one;
      logic [7:0] pin_two;
      logic       level;
   } drive_type;

endpackage

// File: rtl/core/delayed_dual_pin_load_driver_top.sv
// Delayed dual-pin load driver: a table of up to MAX_LOADS loads, each with two
// drive pins and its own switch-on and switch-off delay in ticks. Requests are
// clear table, register load, command load and time tick. Clear and register are
// done in the idle state without a walk. Command and tick walk the registered
// entries through one shared evaluation unit, one entry per cycle, limited by the
// single read port of the table; the walk holds on an entry while a due result
// cannot leave because the response side stalls. A tick emits one response per
// load whose counter has reached the delay of its current level, in table order,
// with last_of_run set on the final one; a tick with nothing due and a command
// emit none. req_stall is high while a walk runs.
// Depends on dpl_pkg, dpl_table, dpl_eval, dpl_ctrl.
module delayed_dual_pin_load_driver_top import dpl_pkg::*; #(
   parameter int MAX_LOADS = DPL_MAX_LOADS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_first_pin,
   input  logic [7:0] req_second_pin,
   input  logic [7:0] req_activation_delay,
   input  logic [7:0] req_deactivation_delay,
   input  logic       req_on_request,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_load_slot,
   output logic [7:0] rsp_drive_pin_one,
   output logic [7:0] rsp_drive_pin_two,
   output logic       rsp_drive_level,
   output logic       rsp_last_of_run
);

   localparam int IDX_W = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1;
   localparam int CNT_W = $clog2(MAX_LOADS + 1);

   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   tbl_wr_type       wr_ctl;
   load_cfg_type     wr_cfg;
   load_dyn_type     wr_dyn;
   load_cfg_type     rd_cfg;
   load_dyn_type     rd_dyn;
   op_type           op;
   eval_type         ev;

   // entry storage, read data registered
   dpl_table #(.MAX_LOADS(MAX_LOADS), .IDX_W(IDX_W)) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_ctl  (wr_ctl),
      .wr_cfg  (wr_cfg),
      .wr_dyn  (wr_dyn),
      .rd_cfg  (rd_cfg),
      .rd_dyn  (rd_dyn)
   );

   // match / due / saturating increment on the entry just read
   dpl_eval u_eval (
      .op  (op),
      .cfg (rd_cfg),
      .dyn (rd_dyn),
      .ev  (ev)
   );

   // walk sequencer, pending result and output register
   dpl_ctrl #(.MAX_LOADS(MAX_LOADS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_first_pin          (req_first_pin),
      .req_second_pin         (req_second_pin),
      .req_activation_delay   (req_activation_delay),
      .req_deactivation_delay (req_deactivation_delay),
      .req_on_request         (req_on_request),
      .rd_cfg                 (rd_cfg),
      .ev                     (ev),
      .op                     (op),
      .rd_addr                (rd_addr),
      .wr_addr                (wr_addr),
      .wr_ctl                 (wr_ctl),
      .wr_cfg                 (wr_cfg),
      .wr_dyn                 (wr_dyn),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_load_slot          (rsp_load_slot),
      .rsp_drive_pin_one      (rsp_drive_pin_one),
      .rsp_drive_pin_two      (rsp_drive_pin_two),
      .rsp_drive_level        (rsp_drive_level),
      .rsp_last_of_run        (rsp_last_of_run)
   );

endmodule

// File: rtl/core/dpl_table.sv
// Load table: static entry memory plus counter and level memories.
// Counter and level carry per-entry valid bits so unwritten entries read as zero.
// Depends on dpl_pkg.
module dpl_table import dpl_pkg::*; #(
   parameter int MAX_LOADS = DPL_MAX_LOADS,
   parameter int IDX_W     = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic [IDX_W-1:0] wr_addr,
   input  tbl_wr_type       wr_ctl,
   input  load_cfg_type     wr_cfg,
   input  load_dyn_type     wr_dyn,
   output load_cfg_type     rd_cfg,
   output load_dyn_type     rd_dyn
);

   load_cfg_type cfg_mem [MAX_LOADS];
   logic [7:0]   cnt_mem [MAX_LOADS];
   logic         lvl_mem [MAX_LOADS];

   logic [MAX_LOADS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [MAX_LOADS-1:0] lvl_vld_ff, lvl_vld_in;

   load_cfg_type rd_cfg_ff;
   logic [7:0]   rd_cnt_ff;
   logic         rd_lvl_ff;
   logic         rd_cnt_ok_ff;
   logic         rd_lvl_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.cfg_we) begin
         cfg_mem[wr_addr] <= wr_cfg;
      end
      if (wr_ctl.cnt_we) begin
         cnt_mem[wr_addr] <= wr_dyn.count;
      end
      if (wr_ctl.lvl_we) begin
         lvl_mem[wr_addr] <= wr_dyn.level;
      end
      rd_cfg_ff    <= cfg_mem[rd_addr];
      rd_cnt_ff    <= cnt_mem[rd_addr];
      rd_lvl_ff    <= lvl_mem[rd_addr];
      rd_cnt_ok_ff <= cnt_vld_ff[rd_addr];
      rd_lvl_ok_ff <= lvl_vld_ff[rd_addr];
   end

   always_comb begin
      cnt_vld_in = cnt_vld_ff;
      lvl_vld_in = lvl_vld_ff;
      if (wr_ctl.cnt_we) begin
         cnt_vld_in[wr_addr] = 1'b1;
      end
      if (wr_ctl.lvl_we) begin
         lvl_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         lvl_vld_ff <= '0;
      end else begin
         cnt_vld_ff <= cnt_vld_in;
         lvl_vld_ff <= lvl_vld_in;
      end
   end

   assign rd_cfg       = rd_cfg_ff;
   assign rd_dyn.count = rd_cnt_ok_ff ? rd_cnt_ff : 8'd0;
   assign rd_dyn.level = rd_lvl_ok_ff ? rd_lvl_ff : 1'b0;

endmodule

// File: rtl/core/dpl_eval.sv
// Shared evaluation unit: pin match for commands, due check and
// saturating count for ticks, applied to one table entry per cycle.
// Depends on dpl_pkg.
module dpl_eval import dpl_pkg::*; (
   input  op_type       op,
   input  load_cfg_type cfg,
   input  load_dyn_type dyn,
   output eval_type     ev
);

   logic       hit;
   logic [7:0] thresh;
   logic [7:0] top;

   always_comb begin
      hit    = (cfg.pin_one == op.pin_one) && (cfg.pin_two == op.pin_two);
      thresh = dyn.level ? cfg.on_delay : cfg.off_delay;
      top    = (cfg.on_delay > cfg.off_delay) ? cfg.on_delay : cfg.off_delay;
      ev.due  = op.is_tick && (dyn.count >= thresh);
      ev.next = dyn;
      if (op.is_tick) begin
         if (dyn.count < top) begin
            ev.next.count = dyn.count + 8'd1;
         end
      end else if (hit) begin
         ev.next.count = 8'd0;
         ev.next.level = op.level;
      end
   end

endmodule

// File: rtl/core/dpl_ctrl.sv
// Sequencer: takes requests, walks the table one entry per cycle while no due
// result is blocked, holds one pending drive result and the output register.
// Depends on dpl_pkg.
module dpl_ctrl import dpl_pkg::*; #(
   parameter int MAX_LOADS = DPL_MAX_LOADS,
   parameter int IDX_W     = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1,
   parameter int CNT_W     = $clog2(MAX_LOADS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_action,
   input  logic [7:0]       req_first_pin,
   input  logic [7:0]       req_second_pin,
   input  logic [7:0]       req_activation_delay,
   input  logic [7:0]       req_deactivation_delay,
   input  logic             req_on_request,
   input  load_cfg_type     rd_cfg,
   input  eval_type         ev,
   output op_type           op,
   output logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] wr_addr,
   output tbl_wr_type       wr_ctl,
   output load_cfg_type     wr_cfg,
   output load_dyn_type     wr_dyn,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_load_slot,
   output logic [7:0]       rsp_drive_pin_one,
   output logic [7:0]       rsp_drive_pin_two,
   output logic             rsp_drive_level,
   output logic             rsp_last_of_run
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   op_type           op_ff, op_in;
   logic             pend_valid_ff, pend_valid_in;
   drive_type        pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   drive_type        rsp_ff, rsp_in;
   logic             rsp_last_ff, rsp_last_in;

   action_type       act;
   logic             accept;
   logic             out_free;
   logic             due_hit;
   logic             ev_go;
   logic             last_ent;
   logic             room;
   logic [IDX_W+2:0] idx_ext;

   always_comb begin
      act      = action_type'(req_action);
      accept   = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      due_hit  = ev.due;
      ev_go    = !(due_hit && pend_valid_ff && !out_free);
      last_ent = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
      room     = count_ff < CNT_W'(MAX_LOADS);
      idx_ext  = {3'b000, idx_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (act == ACT_COMMAND || act == ACT_TICK) &&
                count_ff != '0) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (ev_go && last_ent) begin
               state_in = op_ff.is_tick ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      rd_addr       = '0;
      wr_addr       = idx_ff;
      wr_ctl        = '0;
      wr_cfg        = '{pin_one:   req_first_pin,
                        pin_two:   req_second_pin,
                        on_delay:  req_activation_delay,
                        off_delay: req_deactivation_delay};
      wr_dyn        = ev.next;
      idx_in        = idx_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               op_in  = '{is_tick: (act == ACT_TICK),
                          pin_one: req_first_pin,
                          pin_two: req_second_pin,
                          level:   req_on_request};
               unique case (act)
                  ACT_CLEAR: count_in = '0;
                  ACT_REGISTER: begin
                     if (room) begin
                        wr_addr        = count_ff[IDX_W-1:0];
                        wr_ctl.cfg_we  = 1'b1;
                        wr_ctl.cnt_we  = 1'b1;
                        wr_dyn.count   = 8'd0;
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_COMMAND, ACT_TICK: ;
                  default: ;
               endcase
            end
         end
         ST_EVAL: begin
            if (ev_go) begin
               wr_ctl.cnt_we = 1'b1;
               wr_ctl.lvl_we = 1'b1;
               if (last_ent) begin
                  idx_in = '0;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
               if (due_hit) begin
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = '{slot:    idx_ext[2:0],
                                    pin_one: rd_cfg.pin_one,
                                    pin_two: rd_cfg.pin_two,
                                    level:   ev.next.level};
               end
            end else begin
               rd_addr = idx_ff;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign op                = op_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_load_slot     = rsp_ff.slot;
   assign rsp_drive_pin_one = rsp_ff.pin_one;
   assign rsp_drive_pin_two = rsp_ff.pin_two;
   assign rsp_drive_level   = rsp_ff.level;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

// File: rtl/core/dpl_checker.sv
// Port-level checks for the delayed dual-pin load driver, bound to the top level.
// Depends on dpl_pkg and delayed_dual_pin_load_driver_top.
module dpl_checker import dpl_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_load_slot,
   input logic       rsp_last_of_run
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its slot and run marker
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_load_slot) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // clear and register do not start a walk, so req_stall stays low
   a_short_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (action_type'(req_action) == ACT_CLEAR || action_type'(req_action) == ACT_REGISTER)
      |=> !req_stall)
      else $error("clear or register left the block busy");

   // a new response only appears out of a table walk
   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response produced outside a walk");

endmodule

bind delayed_dual_pin_load_driver_top dpl_checker u_dpl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_load_slot   (rsp_load_slot),
   .rsp_last_of_run (rsp_last_of_run)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for delayed_dual_pin_load_driver_top.
// Directed and random requests, a predictor of the load table, and a drive result checker.
// Depends on dpl_pkg and the block's RTL.
module testbench;
   import dpl_pkg::*;

   localparam int LOADS          = DPL_MAX_LOADS;
   localparam int LONG_HOLD      = 300;   // long drive-side hold-off, in cycles
   localparam int TAIL_CYCLES    = 24;    // covers a full tick walk with margin
   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
   localparam int RANDOM_ITEMS   = 140;

   // one expected drive result: the package drive record plus the end-of-run flag
   typedef struct packed {
      drive_type drive;
      logic      last;
   } expected_drive_type;

   // ---------------------------------------------------------------------------------
   // DUT ports; every input starts at a known value
   // ---------------------------------------------------------------------------------
   logic       clock                  = 1'b0;
   logic       reset                  = 1'b1;
   logic       req_valid              = 1'b0;
   logic [1:0] req_action             = ACT_CLEAR;
   logic [7:0] req_first_pin          = 8'h00;
   logic [7:0] req_second_pin         = 8'h00;
   logic [7:0] req_activation_delay   = 8'h00;
   logic [7:0] req_deactivation_delay = 8'h00;
   logic       req_on_request         = 1'b0;
   logic       rsp_stall              = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_load_slot;
   logic [7:0] rsp_drive_pin_one;
   logic [7:0] rsp_drive_pin_two;
   logic       rsp_drive_level;
   logic       rsp_last_of_run;

   delayed_dual_pin_load_driver_top #(
      .MAX_LOADS(LOADS)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_first_pin         (req_first_pin),
      .req_second_pin        (req_second_pin),
      .req_activation_delay  (req_activation_delay),
      .req_deactivation_delay(req_deactivation_delay),
      .req_on_request        (req_on_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_load_slot         (rsp_load_slot),
      .rsp_drive_pin_one     (rsp_drive_pin_one),
      .rsp_drive_pin_two     (rsp_drive_pin_two),
      .rsp_drive_level       (rsp_drive_level),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predicted copy of the load table
   // ---------------------------------------------------------------------------------
   int         loads_in_table;
   logic [7:0] pin_one_of   [LOADS];
   logic [7:0] pin_two_of   [LOADS];
   logic [7:0] on_delay_of  [LOADS];
   logic [7:0] off_delay_of [LOADS];
   logic [7:0] count_of     [LOADS];
   logic       level_of     [LOADS];

   expected_drive_type pending_drives[$];   // drives owed by accepted ticks, oldest first

   // run bookkeeping
   int error_count    = 0;
   int requests_sent  = 0;
   int ticks_sent     = 0;
   int commands_sent  = 0;
   int registrations  = 0;
   int drives_checked = 0;
   int quiet_cycles   = 0;
   int rsp_hold_left  = 0;
   bit idle_enable       = 1'b1;   // random gaps on both sides
   bit long_hold_pending = 1'b0;   // asks the stall process for one long hold-off

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // half the pins come from a tiny pool, so duplicate pairs and matches show up
   function automatic logic [7:0] random_pin();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   // short delays keep loads firing; a few long ones exercise saturation
   function automatic logic [7:0] random_delay();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return 8'($urandom_range(0, 4));
      if (pick < 95) return 8'($urandom_range(0, 20));
      return 8'($urandom_range(200, 255));
   endfunction

   // Apply one accepted request to the predicted table; a tick queues its drives.
   task automatic update_load_table(input action_type act, input logic [7:0] p1,
                                    input logic [7:0] p2, input logic [7:0] on_d,
                                    input logic [7:0] off_d, input logic lvl);
      int                 due_total;
      int                 emitted;
      bit                 due_flag [LOADS];
      logic [7:0]         top;
      expected_drive_type entry;
      case (act)
         ACT_CLEAR: begin
            // only the fill count drops; counters and levels stay behind
            loads_in_table = 0;
         end
         ACT_REGISTER: begin
            // full table: request is dropped
            if (loads_in_table < LOADS) begin
               pin_one_of[loads_in_table]   = p1;
               pin_two_of[loads_in_table]   = p2;
               on_delay_of[loads_in_table]  = on_d;
               off_delay_of[loads_in_table] = off_d;
               count_of[loads_in_table]     = 8'd0;   // level of the slot is kept
               loads_in_table++;
            end
         end
         ACT_COMMAND: begin
            // every matching pair is updated, none is fine too
            for (int i = 0; i < loads_in_table; i++) begin
               if (pin_one_of[i] == p1 && pin_two_of[i] == p2) begin
                  level_of[i] = lvl;
                  count_of[i] = 8'd0;
               end
            end
         end
         default: begin
            // tick: first find who is due, so the last one can be flagged
            due_total = 0;
            for (int i = 0; i < loads_in_table; i++) begin
               due_flag[i] = count_of[i] >= (level_of[i] ? on_delay_of[i] : off_delay_of[i]);
               if (due_flag[i]) due_total++;
            end
            emitted = 0;
            for (int i = 0; i < loads_in_table; i++) begin
               if (due_flag[i]) begin
                  entry.drive.slot    = 3'(i);
                  entry.drive.pin_one = pin_one_of[i];
                  entry.drive.pin_two = pin_two_of[i];
                  entry.drive.level   = level_of[i];
                  entry.last          = (emitted == due_total - 1);
                  pending_drives.push_back(entry);
                  emitted++;
               end
               // counter saturates at the larger delay
               top = (on_delay_of[i] > off_delay_of[i]) ? on_delay_of[i] : off_delay_of[i];
               if (count_of[i] < top) count_of[i] = count_of[i] + 8'd1;
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------------------
   // Request driver. Fields change only at a rising edge. After acceptance valid is
   // left high when the next request follows at once, so it is never dropped and
   // raised in the same step; the caller lowers it before any wait.
   // ---------------------------------------------------------------------------------
   task automatic send_request(input action_type act, input logic [7:0] p1,
                               input logic [7:0] p2, input logic [7:0] on_d,
                               input logic [7:0] off_d, input logic lvl);
      int gap;
      req_valid              <= 1'b1;
      req_action             <= act;
      req_first_pin          <= p1;
      req_second_pin         <= p2;
      req_activation_delay   <= on_d;
      req_deactivation_delay <= off_d;
      req_on_request         <= lvl;
      do @(posedge clock); while (req_stall !== 1'b0);
      update_load_table(act, p1, p2, on_d, off_d, lvl);
      requests_sent++;
      case (act)
         ACT_TICK:     ticks_sent++;
         ACT_COMMAND:  commands_sent++;
         ACT_REGISTER: registrations++;
         default:      ;
      endcase
      gap = (idle_enable && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // don't-care fields get random values so every input bit toggles
   task automatic do_tick();
      send_request(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom));
   endtask

   task automatic do_clear();
      send_request(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom));
   endtask

   task automatic do_register(input logic [7:0] p1, input logic [7:0] p2,
                              input logic [7:0] on_d, input logic [7:0] off_d);
      send_request(ACT_REGISTER, p1, p2, on_d, off_d, 1'($urandom));
   endtask

   task automatic do_command(input logic [7:0] p1, input logic [7:0] p2, input logic lvl);
      send_request(ACT_COMMAND, p1, p2, 8'($urandom), 8'($urandom), lvl);
   endtask

   // Sender pause: nothing offered until every owed drive is back. Commands give no
   // result, so a walk may still be running; wait out its length too.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Drive-side stall: random bursts, or one long hold-off on request. The count of
   // the hold lives here, not in the sender.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         rsp_hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_hold_left = idle_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------
   // Drive result checker: each accepted result against the oldest expectation
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      expected_drive_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         drives_checked++;
         if (pending_drives.size() == 0) begin
            report_mismatch("drive with none owed, load_slot", 8'(rsp_load_slot), 8'h00);
         end else begin
            want = pending_drives.pop_front();
            if (rsp_load_slot !== want.drive.slot)
               report_mismatch("load_slot", 8'(rsp_load_slot), 8'(want.drive.slot));
            if (rsp_drive_pin_one !== want.drive.pin_one)
               report_mismatch("drive_pin_one", rsp_drive_pin_one, want.drive.pin_one);
            if (rsp_drive_pin_two !== want.drive.pin_two)
               report_mismatch("drive_pin_two", rsp_drive_pin_two, want.drive.pin_two);
            if (rsp_drive_level !== want.drive.level)
               report_mismatch("drive_level", 8'(rsp_drive_level), 8'(want.drive.level));
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", 8'(rsp_last_of_run), 8'(want.last));
         end
      end
   end

   // watchdog: too long without any handshake on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // empty table: tick with nothing due, command with nothing to match
   task automatic test_empty_table();
      do_tick();
      do_command(8'h12, 8'h34, 1'b1);
   endtask

   // pin and delay extremes: zero delay fires every tick, 255 never in this window
   task automatic test_delay_extremes();
      do_register(8'h00, 8'hFF, 8'd0, 8'd0);
      do_register(8'hFF, 8'h00, 8'd255, 8'd255);
      do_register(8'hA5, 8'h5A, 8'd1, 8'd2);
      do_tick();
      do_command(8'hFF, 8'h00, 1'b1);
      do_tick();
   endtask

   // duplicate pairs both follow one command; a swapped pair matches nothing;
   // after clear a new load in slot 0 inherits the old slot-0 level
   task automatic test_duplicates_and_clear();
      do_clear();
      do_register(8'h11, 8'h22, 8'd0, 8'd3);
      do_register(8'h11, 8'h22, 8'd2, 8'd0);
      do_command(8'h11, 8'h22, 1'b1);
      do_command(8'h22, 8'h11, 1'b0);
      do_tick();
      do_clear();
      do_register(8'h33, 8'h44, 8'd0, 8'd5);
      do_tick();
   endtask

   // fill the table; the request past capacity is dropped
   task automatic test_table_full();
      for (int i = 0; i < LOADS; i++)
         do_register(8'(8'h40 + i), 8'(8'hC0 - i), 8'(i % 3), 8'd0);
      do_tick();
   endtask

   // hold the drive side off for a long stretch while ticks keep coming, so the
   // walk blocks and the request side stalls; then pause until all drives are in
   task automatic test_result_backpressure();
      idle_enable       = 1'b0;
      long_hold_pending = 1'b1;
      repeat (6) do_tick();
      idle_enable = 1'b1;
      wait_for_drain();
   endtask

   // mostly well-formed traffic: fresh tables, matching commands, many ticks;
   // the rest is noise. One stretch runs with no gaps on either side.
   task automatic test_random_traffic();
      int         done;
      int         pick;
      int         slot;
      int         burst;
      action_type act;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         idle_enable = !(done >= 60 && done < 90);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            do_clear();
            burst = $urandom_range(1, LOADS);
            repeat (burst) do_register(random_pin(), random_pin(), random_delay(),
                                       random_delay());
            done += burst + 1;
         end else if (pick < 20) begin
            act = action_type'($urandom_range(0, 3));
            // a registration into a full table is ignored and does not count
            if (!(act == ACT_REGISTER && loads_in_table == LOADS)) done++;
            send_request(act, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom));
         end else if (pick < 45) begin
            if (loads_in_table > 0 && $urandom_range(0, 3) != 0) begin
               slot = $urandom_range(0, loads_in_table - 1);
               do_command(pin_one_of[slot], pin_two_of[slot], 1'($urandom));
            end else begin
               do_command(random_pin(), random_pin(), 1'($urandom));
            end
            done++;
         end else if (pick < 47) begin
            wait_for_drain();
         end else begin
            do_tick();
            done++;
         end
      end
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      loads_in_table = 0;
      for (int i = 0; i < LOADS; i++) begin
         pin_one_of[i]   = 8'd0;
         pin_two_of[i]   = 8'd0;
         on_delay_of[i]  = 8'd0;
         off_delay_of[i] = 8'd0;
         count_of[i]     = 8'd0;
         level_of[i]     = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_delay_extremes();
      test_duplicates_and_clear();
      test_table_full();
      test_result_backpressure();
      test_random_traffic();
      wait_for_drain();

      $display("summary: %0d requests (%0d ticks, %0d commands, %0d registrations),",
               requests_sent, ticks_sent, commands_sent, registrations);
      $display("summary: %0d drives checked, one %0d-cycle drive hold-off, %0d mismatches",
               drives_checked, LONG_HOLD, error_count);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// File: files.f
rtl/core/dpl_pkg.sv
rtl/core/dpl_table.sv
rtl/core/dpl_eval.sv
rtl/core/dpl_ctrl.sv
rtl/core/delayed_dual_pin_load_driver_top.sv
rtl/core/dpl_checker.sv
tb/sv/testbench.sv
